// File: rtl/decimal_coordinate_parser_macros.svh
// Assertion macros for the decimal coordinate parser.
// Included by the top level; needs nothing else.
`ifndef DECIMAL_COORDINATE_PARSER_MACROS_SVH
`define DECIMAL_COORDINATE_PARSER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DCP_CHECK_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dcp check failed (same cycle)");

// Consequent holds in the cycle after the antecedent.
`define DCP_CHECK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dcp check failed (next cycle)");

`endif

// File: rtl/dcp_pkg.sv
// Shared types and constants for the decimal coordinate parser.
// No dependencies.
package dcp_pkg;

	localparam int INT_BITS    = 32;  // integer part clamps at 2^(INT_BITS-1)-1
	localparam int FRAC_DIGITS = 9;   // fraction digits kept, 1..9

	localparam int INT_W  = 32;
	localparam int FRAC_W = 30;       // fraction held as digits scaled to 10^9
	localparam int CNT_W  = 4;
	localparam int VAL_W  = 64;

	localparam logic [INT_W-1:0] INT_LIMIT =
		INT_W'((64'd1 << (INT_BITS - 1)) - 64'd1);

	// 10^9 and friends for the fraction rounding
	localparam logic [FRAC_W-1:0] FRAC_SCALE = 30'd1_000_000_000;
	localparam logic [31:0]       HALF_SCALE = 32'd500_000_000;
	localparam logic [31:0]       ONE_SCALE  = 32'd1_000_000_000;
	localparam logic [31:0]       TWO_SCALE  = 32'd2_000_000_000;

	// floor(2^62 / 10^9); quotient estimate is (f9 * RECIP) >> RECIP_SHIFT
	localparam int                RECIP_W     = 33;
	localparam int                RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << 62) / 64'd1_000_000_000);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_NODOT = 2'd2
	} status_t;

	// One finished number, handed from the scanner to the converter.
	typedef struct packed {
		status_t           status;
		logic              sat;
		logic              neg;
		logic [INT_W-1:0]  int_mag;
		logic [FRAC_W-1:0] frac9;   // fraction digits * 10^(9-count)
	} ev_t;

endpackage

// File: rtl/dcp_scan.sv
// Character scanner: grammar state machine and accumulators.
// Depends on dcp_pkg.
module dcp_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          char_code,
	input  logic                end_of_input,
	output logic                emit,
	output dcp_pkg::ev_t        ev,
	output logic                at_start
);

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_INT   = 4'b0010,
		PH_FIRST = 4'b0100,
		PH_FRAC  = 4'b1000
	} phase_t;

	// weight of the next fraction digit when the fraction is held over 10^9
	function automatic logic [dcp_pkg::FRAC_W-1:0] place_value(
		input logic [dcp_pkg::CNT_W-1:0] idx
	);
		logic [dcp_pkg::FRAC_W-1:0] p;
		unique case (idx)
			4'd0:    p = 30'd100_000_000;
			4'd1:    p = 30'd10_000_000;
			4'd2:    p = 30'd1_000_000;
			4'd3:    p = 30'd100_000;
			4'd4:    p = 30'd10_000;
			4'd5:    p = 30'd1_000;
			4'd6:    p = 30'd100;
			4'd7:    p = 30'd10;
			4'd8:    p = 30'd1;
			default: p = '0;
		endcase
		return p;
	endfunction

	phase_t                       phase_q, phase_d;
	logic                         neg_q, neg_d;
	logic [dcp_pkg::INT_W-1:0]    int_q, int_d;
	logic [dcp_pkg::FRAC_W-1:0]   f9_q, f9_d;
	logic [dcp_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic                         ovf_q, ovf_d;

	logic                         digit, under, dot, sign;
	logic [3:0]                   dval;
	logic [dcp_pkg::INT_W+3:0]    int_wide;
	logic                         int_ovf;
	logic [dcp_pkg::INT_W-1:0]    int_add;
	logic                         frac_room;
	logic [dcp_pkg::FRAC_W-1:0]   frac_part;
	logic [dcp_pkg::FRAC_W-1:0]   f9_add;
	logic [dcp_pkg::CNT_W-1:0]    cnt_add;

	always_comb begin
		digit = !end_of_input && char_code >= dcp_pkg::CH_ZERO
			&& char_code <= dcp_pkg::CH_NINE;
		under = !end_of_input && char_code == dcp_pkg::CH_UNDER;
		dot   = !end_of_input && char_code == dcp_pkg::CH_DOT;
		sign  = !end_of_input && (char_code == dcp_pkg::CH_MINUS
			|| char_code == dcp_pkg::CH_PLUS);
		dval  = digit ? 4'(char_code - dcp_pkg::CH_ZERO) : 4'd0;

		// int * 10 + d, clamped
		int_wide = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0}
			+ {{dcp_pkg::INT_W{1'b0}}, dval};
		int_ovf  = int_wide > {4'd0, dcp_pkg::INT_LIMIT};
		int_add  = int_ovf ? dcp_pkg::INT_LIMIT : int_wide[dcp_pkg::INT_W-1:0];

		// extra fraction digits are dropped
		frac_room = cnt_q < dcp_pkg::CNT_W'(dcp_pkg::FRAC_DIGITS);
		frac_part = place_value(cnt_q) * {{(dcp_pkg::FRAC_W-4){1'b0}}, dval};
		f9_add    = frac_room ? f9_q + frac_part : f9_q;
		cnt_add   = frac_room ? cnt_q + 4'd1 : cnt_q;

		phase_d = phase_q;
		neg_d   = neg_q;
		int_d   = int_q;
		f9_d    = f9_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		emit    = 1'b0;
		ev      = '0;

		unique case (phase_q)
			PH_START: begin
				if (digit) begin
					int_d   = int_add;
					ovf_d   = ovf_q | int_ovf;
					phase_d = PH_INT;
				end else if (sign) begin
					neg_d   = char_code == dcp_pkg::CH_MINUS;
					phase_d = PH_INT;
				end else begin
					emit      = 1'b1;
					ev.status = dcp_pkg::ST_BAD;
				end
			end
			PH_INT: begin
				if (digit) begin
					int_d = int_add;
					ovf_d = ovf_q | int_ovf;
				end else if (dot) begin
					phase_d = PH_FIRST;
				end else if (!under) begin
					emit      = 1'b1;
					ev.status = dcp_pkg::ST_NODOT;
				end
			end
			PH_FIRST: begin
				if (digit) begin
					f9_d    = f9_add;
					cnt_d   = cnt_add;
					phase_d = PH_FRAC;
				end else begin
					emit      = 1'b1;
					ev.status = dcp_pkg::ST_BAD;
				end
			end
			PH_FRAC: begin
				if (digit) begin
					f9_d  = f9_add;
					cnt_d = cnt_add;
				end else if (!under) begin
					emit       = 1'b1;
					ev.status  = dcp_pkg::ST_OK;
					ev.sat     = ovf_q;
					ev.neg     = neg_q;
					ev.int_mag = int_q;
					ev.frac9   = f9_q;
				end
			end
			default: begin
				phase_d = PH_START;
			end
		endcase

		// every finished number starts the next one from scratch
		if (emit) begin
			phase_d = PH_START;
			neg_d   = 1'b0;
			int_d   = '0;
			f9_d    = '0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			int_q   <= '0;
			f9_q    <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			int_q   <= int_d;
			f9_q    <= f9_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	assign at_start = phase_q == PH_START;

endmodule

// File: rtl/dcp_conv.sv
// Conversion pipeline: rounds the decimal fraction to 32 binary bits,
// builds the Q32.32 magnitude and applies the sign. Depends on dcp_pkg.
module dcp_conv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ev_valid,
	input  dcp_pkg::ev_t                 ev,
	output logic                         room,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [dcp_pkg::VAL_W-1:0]    value,
	output logic [1:0]                   status,
	output logic                         saturated
);

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic can_s1, can_s2, can_s3, can_s4, can_out;

	dcp_pkg::ev_t                          ev_s1;
	logic [dcp_pkg::FRAC_W+dcp_pkg::RECIP_W-1:0] prod_s1;

	dcp_pkg::status_t                      status_s2, status_s3, status_s4;
	logic                                  sat_s2, sat_s3, sat_s4;
	logic                                  neg_s2, neg_s3, neg_s4;
	logic [dcp_pkg::INT_W-1:0]             int_s2, int_s3;
	logic [31:0]                           qe_s2, qe_s3;
	logic [31:0]                           qe_lo_s2;
	logic [31:0]                           rem_s3;
	logic [31:0]                           frac_s3;
	logic [dcp_pkg::VAL_W-1:0]             mag_s4;

	logic [dcp_pkg::VAL_W-1:0]             value_q;
	dcp_pkg::status_t                      status_q;
	logic                                  sat_q;

	// a stage loads when it is empty or its contents move on
	assign can_out = !out_valid_q || !result_stall;
	assign can_s4  = !v_s4 || can_out;
	assign can_s3  = !v_s3 || can_s4;
	assign can_s2  = !v_s2 || can_s3;
	assign can_s1  = !v_s1 || can_s2;
	assign room    = can_s1;

	// quotient estimate, at most two below the rounded quotient
	assign prod_s1  = ev_s1.frac9 * dcp_pkg::RECIP;
	// only the low word of q*10^9 matters: the remainder is below 2^32
	assign qe_lo_s2 = qe_s2 * {2'b00, dcp_pkg::FRAC_SCALE};
	assign frac_s3  = qe_s3 + {31'd0, rem_s3 >= dcp_pkg::ONE_SCALE}
		+ {31'd0, rem_s3 >= dcp_pkg::TWO_SCALE};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_s1)  v_s1        <= ev_valid;
			if (can_s2)  v_s2        <= v_s1;
			if (can_s3)  v_s3        <= v_s2;
			if (can_s4)  v_s4        <= v_s3;
			if (can_out) out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (can_s1 && ev_valid) begin
			ev_s1 <= ev;
		end
		if (can_s2 && v_s1) begin
			status_s2 <= ev_s1.status;
			sat_s2    <= ev_s1.sat;
			neg_s2    <= ev_s1.neg;
			int_s2    <= ev_s1.int_mag;
			qe_s2     <= prod_s1[dcp_pkg::RECIP_SHIFT +: 32];
		end
		if (can_s3 && v_s2) begin
			status_s3 <= status_s2;
			sat_s3    <= sat_s2;
			neg_s3    <= neg_s2;
			int_s3    <= int_s2;
			qe_s3     <= qe_s2;
			rem_s3    <= dcp_pkg::HALF_SCALE - qe_lo_s2;
		end
		if (can_s4 && v_s3) begin
			status_s4 <= status_s3;
			sat_s4    <= sat_s3;
			neg_s4    <= neg_s3;
			mag_s4    <= {int_s3, frac_s3};
		end
		if (can_out && v_s4) begin
			status_q <= status_s4;
			sat_q    <= sat_s4;
			value_q  <= neg_s4 ? (~mag_s4 + 64'd1) : mag_s4;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign status       = status_q;
	assign saturated    = sat_q;

endmodule

// File: rtl/decimal_coordinate_parser.sv
// Top level of the decimal coordinate parser.
// Depends on dcp_pkg, dcp_scan, dcp_conv and decimal_coordinate_parser_macros.svh.
//
// Usage:
//   Character beats enter on char_valid/char_stall with char_code and
//   end_of_input. The text is an optional sign, integer digits, a dot and
//   fraction digits; underscores inside the digits are skipped. The beat that
//   ends a number (first character outside the grammar, or end_of_input)
//   produces one result beat on result_valid/result_stall: value (Q32.32),
//   status (ok, bad start or fraction, missing dot), char_consumed (always 0,
//   the ending character is only looked at) and saturated.
//   Other beats produce no result.
//   Throughput: one character beat per cycle while char_stall is low. The
//   number of the ending beat moves through stages s1 to s4 into the result
//   register, where result_valid offers it. The rounding of the fraction
//   (estimate multiply, remainder multiply, correction, sign) sets the depth
//   of the result pipeline.
//   Reset: arst_n clears the scanner to its start phase and empties the
//   pipeline. Stall: results queue in the five pipeline registers; char_stall
//   rises only when all of them hold a result and result_stall is high.
`include "decimal_coordinate_parser_macros.svh"

module decimal_coordinate_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  logic [7:0]                  char_code,
	input  logic                        end_of_input,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [63:0]          value,
	output logic [1:0]                  status,
	output logic                        char_consumed,
	output logic                        saturated
);

	logic                         room;
	logic                         take;
	logic                         emit;
	logic                         at_start;
	dcp_pkg::ev_t                 ev;
	logic [dcp_pkg::VAL_W-1:0]    value_raw;

	assign char_stall = !room;
	assign take       = char_valid && !char_stall;

	// grammar and accumulators, updated on every accepted beat
	dcp_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.emit         (emit),
		.ev           (ev),
		.at_start     (at_start)
	);

	// fraction rounding and sign, one finished number per beat
	dcp_conv u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (take && emit),
		.ev           (ev),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value_raw),
		.status       (status),
		.saturated    (saturated)
	);

	assign value         = value_raw;
	// the terminating character never belongs to the number
	assign char_consumed = 1'b0;

	// error results carry no number
	`DCP_CHECK_NOW(a_err_zero, clk, arst_n, result_valid && status != dcp_pkg::ST_OK, value == 64'sd0 && !saturated)
	// clamping is only reported on a good number
	`DCP_CHECK_NOW(a_sat_ok, clk, arst_n, result_valid && saturated, status == dcp_pkg::ST_OK)
	// intake stops only behind a held result
	`DCP_CHECK_NOW(a_stall_src, clk, arst_n, char_stall, result_valid && result_stall)
	// end of input always finishes the number in flight
	`DCP_CHECK_NOW(a_eoi_ends, clk, arst_n, take && end_of_input, emit)
	// a finished number leaves the scanner in its start phase
	`DCP_CHECK_NEXT(a_emit_clears, clk, arst_n, take && emit, at_start)

endmodule

// File: sim/tb_decimal_coordinate_parser.sv
`timescale 1ns / 1ps
// Testbench for decimal_coordinate_parser: character beats in, Q32.32 results out.
// Depends on dcp_pkg and the RTL of the block; holds its own predictor and scoreboard.

module tb_decimal_coordinate_parser;

	// One character beat as the sender sees it.
	typedef struct packed {
		logic       eoi;
		logic [7:0] code;
	} char_beat_t;

	// One expected number.
	typedef struct {
		logic signed [63:0] value;
		dcp_pkg::status_t   status;
		logic               consumed;
		logic               sat;
	} coord_result_t;

	typedef enum logic [1:0] {
		SCAN_START,
		SCAN_INT,
		SCAN_FIRST_FRAC,
		SCAN_FRAC
	} scan_phase_t;

	// Tracks the text the block has taken and the numbers it should produce.
	class coord_scoreboard;
		scan_phase_t   phase;
		logic          negative;
		logic [31:0]   int_mag;
		logic [29:0]   frac_digits;
		logic [3:0]    frac_cnt;
		logic          clamped;
		coord_result_t expected_q[$];
		int            errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase       = SCAN_START;
			negative    = 1'b0;
			int_mag     = '0;
			frac_digits = '0;
			frac_cnt    = '0;
			clamped     = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
			errors++;
		endtask

		function void finish_number(logic signed [63:0] v, dcp_pkg::status_t st, logic sat);
			coord_result_t r;
			r.value    = v;
			r.status   = st;
			r.consumed = 1'b0;
			r.sat      = sat;
			expected_q.push_back(r);
			clear();
		endfunction

		function void add_int_digit(logic [3:0] d);
			logic [63:0] limit;
			logic [63:0] next;
			limit = (64'd1 << (dcp_pkg::INT_BITS - 1)) - 64'd1;
			next  = 64'(int_mag) * 64'd10 + 64'(d);
			if (next > limit) begin
				int_mag = 32'(limit);
				clamped = 1'b1;
			end else begin
				int_mag = 32'(next);
			end
		endfunction

		function void add_frac_digit(logic [3:0] d);
			if (frac_cnt < dcp_pkg::FRAC_DIGITS) begin
				frac_digits = 30'(64'(frac_digits) * 64'd10 + 64'(d));
				frac_cnt++;
			end
		endfunction

		// Q32.32 of the number held: fraction rounded to nearest, ties up.
		function logic signed [63:0] fixed_value();
			logic [63:0] div;
			logic [63:0] frac;
			logic [63:0] mag;
			div = 64'd1;
			for (int i = 0; i < frac_cnt; i++)
				div = div * 64'd10;
			frac = ((64'(frac_digits) << 32) + (div >> 1)) / div;
			mag  = (64'(int_mag) << 32) + frac;
			return negative ? -mag : mag;
		endfunction

		function void note_char(logic [7:0] code, logic eoi);
			logic is_digit;
			logic is_under;
			logic [3:0] d;
			is_digit = !eoi && code >= dcp_pkg::CH_ZERO && code <= dcp_pkg::CH_NINE;
			is_under = !eoi && code == dcp_pkg::CH_UNDER;
			d        = 4'(code - dcp_pkg::CH_ZERO);
			case (phase)
				SCAN_START: begin
					if (is_digit) begin
						add_int_digit(d);
						phase = SCAN_INT;
					end else if (!eoi && (code == dcp_pkg::CH_MINUS
						|| code == dcp_pkg::CH_PLUS)) begin
						negative = (code == dcp_pkg::CH_MINUS);
						phase    = SCAN_INT;
					end else begin
						finish_number('0, dcp_pkg::ST_BAD, 1'b0);
					end
				end
				SCAN_INT: begin
					if (is_digit)
						add_int_digit(d);
					else if (!eoi && code == dcp_pkg::CH_DOT)
						phase = SCAN_FIRST_FRAC;
					else if (!is_under)
						finish_number('0, dcp_pkg::ST_NODOT, 1'b0);
				end
				SCAN_FIRST_FRAC: begin
					if (is_digit) begin
						add_frac_digit(d);
						phase = SCAN_FRAC;
					end else begin
						finish_number('0, dcp_pkg::ST_BAD, 1'b0);
					end
				end
				default: begin
					if (is_digit)
						add_frac_digit(d);
					else if (!is_under)
						finish_number(fixed_value(), dcp_pkg::ST_OK, clamped);
				end
			endcase
		endfunction

		task check_result(logic signed [63:0] v, logic [1:0] st, logic cons, logic sat);
			coord_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with none expected, value", v, '0);
				return;
			end
			want = expected_q.pop_front();
			if (v !== want.value)
				report_mismatch("value", v, want.value);
			if (st !== want.status)
				report_mismatch("status", 64'(st), 64'(want.status));
			if (cons !== want.consumed)
				report_mismatch("char_consumed", 64'(cons), 64'(want.consumed));
			if (sat !== want.sat)
				report_mismatch("saturated", 64'(sat), 64'(want.sat));
		endtask
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               char_valid   = 1'b0;
	logic               char_stall;
	logic [7:0]         char_code    = 8'h00;
	logic               end_of_input = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [63:0] value;
	logic [1:0]         status;
	logic               char_consumed;
	logic               saturated;

	coord_scoreboard sb = new();

	// Idle control: when eager, that side never waits.
	bit         sender_eager   = 1'b0;
	bit         receiver_eager = 1'b0;
	int         beats_sent     = 0;
	char_beat_t text_q[$];

	decimal_coordinate_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.status       (status),
		.char_consumed(char_consumed),
		.saturated    (saturated)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Monitor: both channels are sampled at the edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			sb.note_char(char_code, end_of_input);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(value, status, char_consumed, saturated);
	end

	// Receiver: per result, optionally hold stall, then take the next beat; receiver_eager skips the stall.
	initial begin
		int w;
		forever begin
			w = receiver_eager ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				result_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!(arst_n && result_valid)) @(posedge clk);
		end
	end

	// One character beat, after a random gap. Valid stays high into the next
	// beat when that one has no gap.
	task automatic send_beat(input logic [7:0] code, input logic eoi);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid   <= 1'b1;
		char_code    <= code;
		end_of_input <= eoi;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_str(input string s, input bit then_eoi);
		for (int i = 0; i < s.len(); i++)
			send_beat(8'(s[i]), 1'b0);
		if (then_eoi)
			send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic flush_text();
		foreach (text_q[i])
			send_beat(text_q[i].code, text_q[i].eoi);
		text_q.delete();
	endtask

	// Sender holds off until the block has handed back every number.
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		return ($urandom_range(0, 7) == 0) ? dcp_pkg::CH_NINE
			: 8'(dcp_pkg::CH_ZERO + $urandom_range(0, 9));
	endfunction

	// A digit run; underscores only follow a digit.
	function automatic void put_digits(int n);
		for (int i = 0; i < n; i++) begin
			text_q.push_back({1'b0, rand_digit()});
			if ($urandom_range(0, 6) == 0)
				text_q.push_back({1'b0, dcp_pkg::CH_UNDER});
		end
	endfunction

	// Well-formed number with random content and a random terminator;
	// broken ones get one beat overwritten with junk.
	function automatic void put_number(bit broken);
		int         n;
		logic [7:0] r;
		case ($urandom_range(0, 3))
			0: text_q.push_back({1'b0, dcp_pkg::CH_MINUS});
			1: text_q.push_back({1'b0, dcp_pkg::CH_PLUS});
			default: ;
		endcase
		// long integer runs push the magnitude into the clamp
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
		put_digits(n);
		text_q.push_back({1'b0, dcp_pkg::CH_DOT});
		// past nine fraction digits the tail is dropped
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
		put_digits(n);
		r = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0 || (r >= dcp_pkg::CH_ZERO && r <= dcp_pkg::CH_NINE)
			|| r == dcp_pkg::CH_UNDER)
			text_q.push_back({1'b1, r});
		else
			text_q.push_back({1'b0, r});
		if (broken) begin
			n = $urandom_range(0, text_q.size() - 1);
			text_q[n] = {1'($urandom_range(0, 5) == 0), 8'($urandom_range(0, 255))};
		end
	endfunction

	function automatic void put_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			text_q.push_back({1'($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))});
	endfunction

	initial begin
		bit drained;
		int kind;
		drained = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: end of input and '_' at the start, dot right after a sign
		// then end of input, sign after the dot, plus sign with no dot, and a
		// negative number whose integer part clamps.
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		send_str("_", 1'b0);
		send_str("-.", 1'b1);
		send_str("3_1.-", 1'b0);
		send_str("+7;", 1'b0);
		send_str("-2147483648.5", 1'b1);

		// Random: mostly well-formed numbers, some broken ones and noise.
		while (beats_sent < 1350) begin
			if ($urandom_range(0, 15) == 0)
				sender_eager = ~sender_eager;
			if ($urandom_range(0, 15) == 0)
				receiver_eager = ~receiver_eager;
			if (!drained && beats_sent > 700) begin
				wait_drained();
				drained = 1'b1;
			end
			kind = $urandom_range(0, 19);
			if (kind < 15)
				put_number(1'b0);
			else if (kind < 17)
				put_number(1'b1);
			else
				put_noise();
			flush_text();
		end
		// close any number left open by noise
		send_beat(8'h00, 1'b1);

		wait_drained();
		// let results still in the pipeline land; leave room for strays
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: decimal_coordinate_parser.f
+incdir+rtl
rtl/dcp_pkg.sv
rtl/dcp_scan.sv
rtl/dcp_conv.sv
rtl/decimal_coordinate_parser.sv
sim/tb_decimal_coordinate_parser.sv
